// ===== hdl/svpwm_pkg.sv =====
// Package: shared constants and types for the space vector PWM setpoint block.
`default_nettype none
package svpwm_pkg;

  localparam int unsigned VOLT_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned FIX_BITS       = 24;
  localparam int unsigned CFG_WIDTH      = 16;
  localparam int unsigned CFG_IDX_WIDTH  = 2;
  localparam int unsigned MIDQ_DEPTH     = 4;

  localparam logic [FIX_BITS-1:0] INV_SQRT3_Q24     = 24'd9686330;
  localparam logic [FIX_BITS:0]   TWO_INV_SQRT3_Q24 = 25'd19372660;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DC_LINK_VOLTAGE = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PULSE_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PWM_MAX         = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DC_LINK_RESET = 16'd24;
  localparam logic [CFG_WIDTH-1:0] PWM_MAX_RESET = 16'd255;

  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;
  localparam logic [2:0] SEC_6 = 3'd6;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] vdc;
    logic [CFG_WIDTH-1:0] pwm_max;
  } svpwm_cfg_t;

endpackage
`default_nettype wire

// ===== hdl/svpwm_queue.sv =====
// Small register queue between the front and back parts.
`default_nettype none
module svpwm_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [W-1:0]               wr_data,
  input  wire logic                       rd_en,
  output logic [W-1:0]                    rd_data,
  output logic                            q_empty,
  output logic [$clog2(DEPTH):0]          q_count
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign rd_data = mem_r[rp_r];
  assign q_empty = (cnt_r == '0);
  assign q_count = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && !rd_en && cnt_r == (AW+1)'(DEPTH)))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && cnt_r == '0))
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance");

endmodule
`default_nettype wire

// ===== hdl/svpwm_front.sv =====
// Front part: magnitudes, sector, adjacent-vector magnitudes and dividends.
`default_nettype none
module svpwm_front #(
  parameter int unsigned VOLT_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DEPTH      = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [VOLT_WIDTH-1:0]  in_v_alpha,
  input  wire logic signed [VOLT_WIDTH-1:0]  in_v_beta,
  input  wire logic [$clog2(DEPTH):0]        q_count,
  output logic                               q_push,
  output logic [VOLT_WIDTH+FRAC_BITS:0]      q_nr,
  output logic [VOLT_WIDTH+FRAC_BITS:0]      q_nl,
  output logic [2:0]                         q_sector
);
  import svpwm_pkg::*;

  localparam int unsigned VW = VOLT_WIDTH;
  localparam int unsigned MW = VW + FIX_BITS;
  localparam int unsigned SH = FIX_BITS + 1 - FRAC_BITS;
  localparam int unsigned CW = $clog2(DEPTH) + 1;

  logic          v0_r, v1_r;
  logic [VW-1:0] a0_r, b0_r, a1_r;
  logic          an0_r, bn0_r, an1_r, bn1_r;
  logic [MW-1:0] bs1_r, mc1_r;

  logic [VW-1:0] a_raw, b_raw;
  logic          accept;
  logic [MW-1:0] aq, ma, mb, ur, ul;
  logic          bneg;
  logic [2:0]    sec;
  logic [MW+1:0] nr3, nl3;

  assign a_raw  = in_v_alpha;
  assign b_raw  = in_v_beta;
  assign full   = (CW'(v0_r) + CW'(v1_r) + q_count) >= CW'(DEPTH);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    an0_r <= a_raw[VW-1];
    bn0_r <= b_raw[VW-1];
    a0_r  <= a_raw[VW-1] ? (~a_raw + 1'b1) : a_raw;
    b0_r  <= b_raw[VW-1] ? (~b_raw + 1'b1) : b_raw;
    an1_r <= an0_r;
    bn1_r <= bn0_r;
    a1_r  <= a0_r;
    bs1_r <= MW'(b0_r * INV_SQRT3_Q24);
    mc1_r <= MW'(b0_r * TWO_INV_SQRT3_Q24);
  end

  always_comb begin
    aq   = {a1_r, {FIX_BITS{1'b0}}};
    ma   = aq + bs1_r;
    bneg = aq < bs1_r;
    mb   = bneg ? (bs1_r - aq) : (aq - bs1_r);
    if (!bn1_r) begin
      sec = an1_r ? (bneg ? SEC_2 : SEC_3) : (bneg ? SEC_2 : SEC_1);
    end else begin
      sec = an1_r ? (bneg ? SEC_5 : SEC_4) : (bneg ? SEC_5 : SEC_6);
    end
    if (sec == SEC_1 || sec == SEC_4) begin
      ur = mb;
      ul = mc1_r;
    end else if (sec == SEC_3 || sec == SEC_6) begin
      ur = mc1_r;
      ul = mb;
    end else if (an1_r == bn1_r) begin
      ur = ma;
      ul = mb;
    end else begin
      ur = mb;
      ul = ma;
    end
    nr3 = {1'b0, ur, 1'b0} + {2'b00, ur};
    nl3 = {1'b0, ul, 1'b0} + {2'b00, ul};
  end

  assign q_push   = v1_r;
  assign q_nr     = nr3[MW+1:SH];
  assign q_nl     = nl3[MW+1:SH];
  assign q_sector = sec;

  assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (q_count != CW'(DEPTH)))
    else $error("front pushed into a full queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v0_r)
    else $error("accepted beat lost in front");
  assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && a1_r == '0 && bs1_r == '0) |-> (sec == SEC_1))
    else $error("zero vector not in first sector");

endmodule
`default_nettype wire

// ===== hdl/svpwm_back.sv =====
// Back part: pipelined dwell-fraction divider, zero time and compare values.
`default_nettype none
module svpwm_back #(
  parameter int unsigned VOLT_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire svpwm_pkg::svpwm_cfg_t             cfg,
  input  wire logic                              q_empty,
  input  wire logic [VOLT_WIDTH+FRAC_BITS:0]     q_nr,
  input  wire logic [VOLT_WIDTH+FRAC_BITS:0]     q_nl,
  input  wire logic [2:0]                        q_sector,
  output logic                                   q_pop,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [svpwm_pkg::CFG_WIDTH-1:0]        out_u_setpoint,
  output logic [svpwm_pkg::CFG_WIDTH-1:0]        out_v_setpoint,
  output logic [svpwm_pkg::CFG_WIDTH-1:0]        out_w_setpoint,
  output logic [2:0]                             out_sector,
  output logic                                   out_overmodulated
);
  import svpwm_pkg::*;

  localparam int unsigned NW = VOLT_WIDTH + FRAC_BITS + 1;
  localparam int unsigned CW = CFG_WIDTH;
  localparam int unsigned FB = FRAC_BITS;
  localparam logic [NW+1:0] ONE = (NW+2)'(1) << FB;

  logic          adv;
  logic          out_v_r;

  logic [NW-1:0] xr_r [NW+1];
  logic [NW-1:0] xl_r [NW+1];
  logic [CW-1:0] rr_r [NW+1];
  logic [CW-1:0] rl_r [NW+1];
  logic [2:0]    sec_r [NW+1];
  logic          v_r [NW+1];

  assign adv   = !out_v_r || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xr_r[0]  <= q_nr;
      xl_r[0]  <= q_nl;
      rr_r[0]  <= '0;
      rl_r[0]  <= '0;
      sec_r[0] <= q_sector;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [CW:0] r2r, r2l;
    logic        ger, gel;

    assign r2r = {rr_r[k], xr_r[k][NW-1]};
    assign r2l = {rl_r[k], xl_r[k][NW-1]};
    assign ger = r2r >= {1'b0, cfg.vdc};
    assign gel = r2l >= {1'b0, cfg.vdc};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        xr_r[k+1]  <= {xr_r[k][NW-2:0], ger};
        xl_r[k+1]  <= {xl_r[k][NW-2:0], gel};
        rr_r[k+1]  <= ger ? CW'(r2r - {1'b0, cfg.vdc}) : CW'(r2r);
        rl_r[k+1]  <= gel ? CW'(r2l - {1'b0, cfg.vdc}) : CW'(r2l);
        sec_r[k+1] <= sec_r[k];
      end
    end
  end

  // zero time and cumulative fractions
  logic          s1_v_r, s1_over_r;
  logic [2:0]    s1_sec_r;
  logic [FB:0]   s1_c0_r, s1_c1_r, s1_c2_r;

  logic [NW+1:0] sum, f0, x1, x2, sel;
  logic          over, odd_sec;

  always_comb begin
    sum     = (NW+2)'(xr_r[NW]) + (NW+2)'(xl_r[NW]);
    over    = sum > ONE;
    f0      = over ? '0 : ((ONE - sum) >> 1);
    odd_sec = (sec_r[NW] == SEC_1) || (sec_r[NW] == SEC_3) || (sec_r[NW] == SEC_5);
    sel     = odd_sec ? (NW+2)'(xr_r[NW]) : (NW+2)'(xl_r[NW]);
    x1      = f0 + sel;
    x2      = f0 + sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= v_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_over_r <= over;
      s1_sec_r  <= sec_r[NW];
      s1_c0_r   <= (f0 > ONE) ? ONE[FB:0] : f0[FB:0];
      s1_c1_r   <= (x1 > ONE) ? ONE[FB:0] : x1[FB:0];
      s1_c2_r   <= (x2 > ONE) ? ONE[FB:0] : x2[FB:0];
    end
  end

  // scale into compare values and route per sector
  logic [CW+FB:0] p0, p1, p2;
  logic [CW-1:0]  c0, c1, c2;
  logic [CW-1:0]  u_nxt, v_nxt, w_nxt;

  always_comb begin
    p0 = cfg.pwm_max * s1_c0_r;
    p1 = cfg.pwm_max * s1_c1_r;
    p2 = cfg.pwm_max * s1_c2_r;
    c0 = p0[FB+CW-1:FB];
    c1 = p1[FB+CW-1:FB];
    c2 = p2[FB+CW-1:FB];
    unique case (s1_sec_r)
      SEC_1:   begin u_nxt = c0; v_nxt = c1; w_nxt = c2; end
      SEC_2:   begin v_nxt = c0; u_nxt = c1; w_nxt = c2; end
      SEC_3:   begin v_nxt = c0; w_nxt = c1; u_nxt = c2; end
      SEC_4:   begin w_nxt = c0; v_nxt = c1; u_nxt = c2; end
      SEC_5:   begin w_nxt = c0; u_nxt = c1; v_nxt = c2; end
      default: begin u_nxt = c0; w_nxt = c1; v_nxt = c2; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_u_setpoint    <= u_nxt;
      out_v_setpoint    <= v_nxt;
      out_w_setpoint    <= w_nxt;
      out_sector        <= s1_sec_r;
      out_overmodulated <= s1_over_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_sector != 3'd0 && out_sector != 3'd7))
    else $error("result beat with invalid sector");
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_over_r) |-> (s1_c0_r == '0))
    else $error("zero time not cleared on overmodulation");
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_c0_r <= s1_c1_r && s1_c1_r <= s1_c2_r))
    else $error("cumulative fractions out of order");

endmodule
`default_nettype wire

// ===== hdl/space_vector_pwm_setpoints.sv =====
// Path from an accepted push to the out_ ports: front registers v0_r and v1_r, mid queue,
// back input stage, the divider pipeline (one quotient bit per stage), s1, output register.
// Throughput: one beat per cycle both sides unless full; back holds while a result waits.
// Reset: synchronous active-low; clears all valid flags and queue pointers and loads
// dc_link_voltage = 24, pwm_max = 255. No clearing pass.
`default_nettype none
module space_vector_pwm_setpoints #(
  parameter int unsigned VOLT_WIDTH = svpwm_pkg::VOLT_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = svpwm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [VOLT_WIDTH-1:0]         in_v_alpha,
  input  wire logic signed [VOLT_WIDTH-1:0]         in_v_beta,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic [svpwm_pkg::CFG_WIDTH-1:0]           out_u_setpoint,
  output logic [svpwm_pkg::CFG_WIDTH-1:0]           out_v_setpoint,
  output logic [svpwm_pkg::CFG_WIDTH-1:0]           out_w_setpoint,
  output logic [2:0]                                out_sector,
  output logic                                      out_overmodulated,
  input  wire logic                                 cfg_we,
  input  wire logic [svpwm_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [svpwm_pkg::CFG_WIDTH-1:0]      cfg_wdata
);
  import svpwm_pkg::*;

  localparam int unsigned NW = VOLT_WIDTH + FRAC_BITS + 1;
  localparam int unsigned QW = 2 * NW + 3;
  localparam int unsigned QC = $clog2(MIDQ_DEPTH) + 1;

  logic [CFG_WIDTH-1:0] vdc_r, pwm_max_r;
  svpwm_cfg_t           cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdc_r     <= DC_LINK_RESET;
      pwm_max_r <= PWM_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DC_LINK_VOLTAGE: vdc_r     <= cfg_wdata;
        CFG_PWM_MAX:         pwm_max_r <= cfg_wdata;
        CFG_PULSE_PERIOD:    ;
        default:             ;
      endcase
    end
  end

  assign cfg.vdc     = (vdc_r == '0) ? CFG_WIDTH'(1) : vdc_r;
  assign cfg.pwm_max = pwm_max_r;

  logic          q_push, q_pop, q_empty;
  logic [QC-1:0] q_count;
  logic [NW-1:0] f_nr, f_nl, b_nr, b_nl;
  logic [2:0]    f_sec, b_sec;
  logic [QW-1:0] q_rd;

  svpwm_front #(
    .VOLT_WIDTH (VOLT_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .DEPTH      (MIDQ_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_v_alpha (in_v_alpha),
    .in_v_beta  (in_v_beta),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_nr       (f_nr),
    .q_nl       (f_nl),
    .q_sector   (f_sec)
  );

  svpwm_queue #(
    .W     (QW),
    .DEPTH (MIDQ_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data ({f_sec, f_nl, f_nr}),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .q_empty (q_empty),
    .q_count (q_count)
  );

  assign b_nr  = q_rd[NW-1:0];
  assign b_nl  = q_rd[2*NW-1:NW];
  assign b_sec = q_rd[QW-1:2*NW];

  svpwm_back #(
    .VOLT_WIDTH (VOLT_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_empty           (q_empty),
    .q_nr              (b_nr),
    .q_nl              (b_nl),
    .q_sector          (b_sec),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_u_setpoint    (out_u_setpoint),
    .out_v_setpoint    (out_v_setpoint),
    .out_w_setpoint    (out_w_setpoint),
    .out_sector        (out_sector),
    .out_overmodulated (out_overmodulated)
  );

endmodule
`default_nettype wire
